@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define MOPZ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mopz assertion failed");

// Condition implies consequence in the same cycle
`define MOPZ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    `MOPZ_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Condition implies consequence in the next cycle
`define MOPZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    `MOPZ_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

@@ rtl/mopz_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mopz_pkg;

    localparam int PIXEL_FRAC_BITS = 4;
    localparam int REG_W     = 12;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = 4;
    localparam int PROD_W    = 2 * REG_W;
    localparam int EST_W     = PROD_W + 1;
    localparam int DIST_W    = 25;

    localparam logic signed [EST_W-1:0] NO_ESTIMATE_MM = -EST_W'(1000);
    localparam logic signed [DIST_W-1:0] ZONE_CRITICAL_MM = DIST_W'(3000);
    localparam logic signed [DIST_W-1:0] ZONE_WARNING_MM  = DIST_W'(10000);
    localparam logic signed [DIST_W-1:0] ZONE_CAUTION_MM  = DIST_W'(20000);
    localparam logic [7:0] ORANGE_GREEN = 8'd166;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_FOCAL   = 4'd0;
    localparam logic [IDX_W-1:0] REG_CAM     = 4'd1;
    localparam logic [IDX_W-1:0] REG_IMG     = 4'd2;
    localparam logic [IDX_W-1:0] REG_CLASS0  = 4'd3;
    localparam logic [IDX_W-1:0] REG_CLASS1  = 4'd4;
    localparam logic [IDX_W-1:0] REG_CLASS2  = 4'd5;
    localparam logic [IDX_W-1:0] REG_CLASS3  = 4'd6;
    localparam logic [IDX_W-1:0] REG_DEFAULT = 4'd7;

    typedef enum logic [1:0] {
        ZONE_CRITICAL = 2'd0,
        ZONE_WARNING  = 2'd1,
        ZONE_CAUTION  = 2'd2,
        ZONE_SAFE     = 2'd3
    } zone_t;

    typedef struct packed {
        logic [REG_W-1:0] focal_px;
        logic [REG_W-1:0] camera_height_mm;
        logic [REG_W-1:0] image_height_px;
        logic [REG_W-1:0] class0_height_mm;
        logic [REG_W-1:0] class1_height_mm;
        logic [REG_W-1:0] class2_height_mm;
        logic [REG_W-1:0] class3_height_mm;
        logic [REG_W-1:0] default_height_mm;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        focal_px:          12'd700,
        camera_height_mm:  12'd1200,
        image_height_px:   12'd360,
        class0_height_mm:  12'd1500,
        class1_height_mm:  12'd1200,
        class2_height_mm:  12'd1700,
        class3_height_mm:  12'd1000,
        default_height_mm: 12'd1500
    };

endpackage

`default_nettype wire

@@ rtl/mopz_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Object item channel
interface mopz_obj_if;
    logic        valid;
    logic        ready;
    logic [7:0]  obj_class;
    logic [15:0] box_top;
    logic [15:0] box_height;

    modport source (output valid, obj_class, box_top, box_height, input ready);
    modport sink   (input valid, obj_class, box_top, box_height, output ready);
endinterface

// Result item channel
interface mopz_res_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] distance_mm;
    logic [1:0]         zone;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [2:0]         outline_px;

    modport source (output valid, distance_mm, zone, red, green, blue, outline_px,
                    input ready);
    modport sink   (input valid, distance_mm, zone, red, green, blue, outline_px,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/monocular_object_proximity_zone.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Monocular object proximity zone: for each object item (class, box top,
// box height in pixels with PIXEL_FRAC_BITS fraction bits) gives one result
// item with the average of a pinhole and a ground-plane distance estimate in
// mm, its proximity zone and border colour and width. Fully pipelined: one
// item per cycle while the result side does not stall. Two restoring
// dividers run side by side and resolve one quotient bit per stage over
// 24 + PIXEL_FRAC_BITS stages, behind an input product stage and ahead of an
// output classification stage. A stall on the result side holds the whole
// pipeline. Registers are written through cfg_we/cfg_index/cfg_wdata; the
// user must write them only while the block is idle, as the block itself does
// not enforce it; indexes above 7 are ignored.
module monocular_object_proximity_zone #(
    parameter int PIXEL_FRAC_BITS = mopz_pkg::PIXEL_FRAC_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [mopz_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [mopz_pkg::REG_W-1:0]  cfg_wdata,
    mopz_obj_if.sink                         req,
    mopz_res_if.source                       rsp
);
    import mopz_pkg::*;

    localparam int NW = PROD_W + PIXEL_FRAC_BITS;
    localparam int DW = ((REG_W + PIXEL_FRAC_BITS) > 16) ? (REG_W + PIXEL_FRAC_BITS) : 16;

    cfg_t          cfg_reg;
    logic          en;
    logic          front_vld_reg;
    logic [NW-1:0] div_vld_reg;
    logic [NW-1:0] pin_num;
    logic [DW-1:0] pin_den;
    logic          pin_bad;
    logic [NW-1:0] gnd_num;
    logic [DW-1:0] gnd_den;
    logic          gnd_bad;
    logic [NW-1:0] pin_q;
    logic          pin_q_bad;
    logic [NW-1:0] gnd_q;
    logic          gnd_q_bad;

    // Pipeline advances unless a result is held
    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FOCAL:   cfg_reg.focal_px          <= cfg_wdata;
                REG_CAM:     cfg_reg.camera_height_mm  <= cfg_wdata;
                REG_IMG:     cfg_reg.image_height_px   <= cfg_wdata;
                REG_CLASS0:  cfg_reg.class0_height_mm  <= cfg_wdata;
                REG_CLASS1:  cfg_reg.class1_height_mm  <= cfg_wdata;
                REG_CLASS2:  cfg_reg.class2_height_mm  <= cfg_wdata;
                REG_CLASS3:  cfg_reg.class3_height_mm  <= cfg_wdata;
                REG_DEFAULT: cfg_reg.default_height_mm <= cfg_wdata;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= 1'b0;
            div_vld_reg   <= '0;
        end
        else if (en)
        begin
            front_vld_reg <= req.valid;
            div_vld_reg   <= {div_vld_reg[NW-2:0], front_vld_reg};
        end
    end

    mopz_front #(.FRAC(PIXEL_FRAC_BITS), .NW(NW), .DW(DW)) u_front (
        .clk        (clk),
        .en         (en),
        .obj_class  (req.obj_class),
        .box_top    (req.box_top),
        .box_height (req.box_height),
        .cfg        (cfg_reg),
        .pin_num    (pin_num),
        .pin_den    (pin_den),
        .pin_bad    (pin_bad),
        .gnd_num    (gnd_num),
        .gnd_den    (gnd_den),
        .gnd_bad    (gnd_bad)
    );

    mopz_div #(.NW(NW), .DW(DW)) u_div_pin (
        .clk     (clk),
        .en      (en),
        .num     (pin_num),
        .den     (pin_den),
        .bad_in  (pin_bad),
        .quo     (pin_q),
        .bad_out (pin_q_bad)
    );

    mopz_div #(.NW(NW), .DW(DW)) u_div_gnd (
        .clk     (clk),
        .en      (en),
        .num     (gnd_num),
        .den     (gnd_den),
        .bad_in  (gnd_bad),
        .quo     (gnd_q),
        .bad_out (gnd_q_bad)
    );

    mopz_zone #(.NW(NW)) u_zone (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (div_vld_reg[NW-1]),
        .pin_q   (pin_q),
        .pin_bad (pin_q_bad),
        .gnd_q   (gnd_q),
        .gnd_bad (gnd_q_bad),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

@@ rtl/mopz_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mopz_front #(
    parameter int FRAC = 4,
    parameter int NW   = 28,
    parameter int DW   = 16
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [7:0]       obj_class,
    input  wire logic [15:0]      box_top,
    input  wire logic [15:0]      box_height,
    input  wire mopz_pkg::cfg_t   cfg,
    output logic      [NW-1:0]    pin_num,
    output logic      [DW-1:0]    pin_den,
    output logic                  pin_bad,
    output logic      [NW-1:0]    gnd_num,
    output logic      [DW-1:0]    gnd_den,
    output logic                  gnd_bad
);
    import mopz_pkg::*;

    localparam int IMG_W = REG_W + FRAC;
    localparam int DFW   = ((IMG_W > 17) ? IMG_W : 17) + 1;

    logic [REG_W-1:0]      real_h;
    logic [PROD_W-1:0]     pin_prod;
    logic [PROD_W-1:0]     gnd_prod;
    logic [16:0]           bottom;
    logic signed [DFW-1:0] ydiff;

    // Real height by class
    always_comb
    begin
        case (obj_class)
            8'd0:    real_h = cfg.class0_height_mm;
            8'd1:    real_h = cfg.class1_height_mm;
            8'd2:    real_h = cfg.class2_height_mm;
            8'd3:    real_h = cfg.class3_height_mm;
            default: real_h = cfg.default_height_mm;
        endcase
    end

    // Products and ground divisor
    always_comb
    begin
        pin_prod = PROD_W'(real_h) * PROD_W'(cfg.focal_px);
        gnd_prod = PROD_W'(cfg.camera_height_mm) * PROD_W'(cfg.focal_px);
        bottom   = {1'b0, box_top} + {1'b0, box_height};
        ydiff    = signed'(DFW'(cfg.image_height_px) << FRAC) - signed'(DFW'(bottom));
    end

    // Stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pin_num <= NW'(pin_prod) << FRAC;
            gnd_num <= NW'(gnd_prod) << FRAC;
            pin_den <= DW'(box_height);
            pin_bad <= {1'b0, box_height} < (17'd1 << FRAC);
            gnd_den <= ydiff[DW-1:0];
            gnd_bad <= ydiff < signed'(DFW'(1) << FRAC);
        end
    end

endmodule

`default_nettype wire

@@ rtl/mopz_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage
module mopz_div #(
    parameter int NW = 28,
    parameter int DW = 16
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic          bad_in,
    output logic      [NW-1:0] quo,
    output logic               bad_out
);
    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] nq_reg  [NW];
    logic [DW-1:0] den_reg [NW];
    logic          bad_reg [NW];

    genvar s;
    generate
        for (s = 0; s < NW; s++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [NW-1:0] nq_in;
            logic [DW-1:0] den_in;
            logic          bad_i;
            logic [DW:0]   trial;
            logic [DW+1:0] diff;

            if (s == 0)
            begin : g_first
                assign rem_in = '0;
                assign nq_in  = num;
                assign den_in = den;
                assign bad_i  = bad_in;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[s-1];
                assign nq_in  = nq_reg[s-1];
                assign den_in = den_reg[s-1];
                assign bad_i  = bad_reg[s-1];
            end

            // Trial subtract; sign bit is the borrow
            assign trial = {rem_in, nq_in[NW-1]};
            assign diff  = {1'b0, trial} - {2'b00, den_in};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= diff[DW+1] ? trial[DW-1:0] : diff[DW-1:0];
                    nq_reg[s]  <= {nq_in[NW-2:0], ~diff[DW+1]};
                    den_reg[s] <= den_in;
                    bad_reg[s] <= bad_i;
                end
            end
        end
    endgenerate

    assign quo     = nq_reg[NW-1];
    assign bad_out = bad_reg[NW-1];

endmodule

`default_nettype wire

@@ rtl/mopz_zone.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mopz_zone #(
    parameter int NW = 28
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vld_in,
    input  wire logic [NW-1:0] pin_q,
    input  wire logic          pin_bad,
    input  wire logic [NW-1:0] gnd_q,
    input  wire logic          gnd_bad,
    mopz_res_if.source         rsp
);
    import mopz_pkg::*;

    logic signed [EST_W-1:0]  pin_est;
    logic signed [EST_W-1:0]  gnd_est;
    logic signed [EST_W:0]    sum;
    logic signed [DIST_W-1:0] avg;
    zone_t                    zone;
    logic [7:0]               red;
    logic [7:0]               green;
    logic [2:0]               bw;
    logic                     vld_reg;
    logic signed [DIST_W-1:0] dist_reg;
    zone_t                    zone_reg;
    logic [7:0]               red_reg;
    logic [7:0]               green_reg;
    logic [2:0]               bw_reg;

    // Sentinel substitution, average, classification
    always_comb
    begin
        pin_est = pin_bad ? NO_ESTIMATE_MM : signed'({1'b0, pin_q[PROD_W-1:0]});
        gnd_est = gnd_bad ? NO_ESTIMATE_MM : signed'({1'b0, gnd_q[PROD_W-1:0]});
        sum     = {pin_est[EST_W-1], pin_est} + {gnd_est[EST_W-1], gnd_est};
        avg     = sum[EST_W:1];
        if (avg < ZONE_CRITICAL_MM)
        begin
            zone = ZONE_CRITICAL; red = 8'd255; green = 8'd0;         bw = 3'd5;
        end
        else if (avg < ZONE_WARNING_MM)
        begin
            zone = ZONE_WARNING;  red = 8'd255; green = ORANGE_GREEN; bw = 3'd4;
        end
        else if (avg < ZONE_CAUTION_MM)
        begin
            zone = ZONE_CAUTION;  red = 8'd255; green = 8'd255;       bw = 3'd3;
        end
        else
        begin
            zone = ZONE_SAFE;     red = 8'd0;   green = 8'd255;       bw = 3'd3;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg  <= avg;
            zone_reg  <= zone;
            red_reg   <= red;
            green_reg <= green;
            bw_reg    <= bw;
        end
    end

    assign rsp.valid       = vld_reg;
    assign rsp.distance_mm = dist_reg;
    assign rsp.zone        = zone_reg;
    assign rsp.red         = red_reg;
    assign rsp.green       = green_reg;
    assign rsp.blue        = 8'd0;
    assign rsp.outline_px  = bw_reg;

endmodule

`default_nettype wire

@@ rtl/mopz_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mopz_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [24:0] distance_mm,
    input wire logic [1:0]         zone,
    input wire logic [7:0]         red,
    input wire logic [7:0]         blue,
    input wire logic [2:0]         outline_px
);
    import mopz_pkg::*;

    // A held result keeps its distance
    `MOPZ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(distance_mm))

    // Critical zone exactly below the first threshold
    `MOPZ_ASSERT_IMPL(a_crit, clk, rst_n, out_valid, (zone == ZONE_CRITICAL) == (distance_mm < ZONE_CRITICAL_MM))

    // Red is off only in the safe zone
    `MOPZ_ASSERT_IMPL(a_red, clk, rst_n, out_valid, (red == 8'd0) == (zone == ZONE_SAFE))

    // Blue off; width follows zone
    `MOPZ_ASSERT_IMPL(a_bw, clk, rst_n, out_valid, blue == 8'd0 && ((zone == ZONE_CRITICAL) == (outline_px == 3'd5)))

endmodule

bind monocular_object_proximity_zone mopz_checker u_mopz_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .distance_mm  (rsp.distance_mm),
    .zone         (rsp.zone),
    .red          (rsp.red),
    .blue         (rsp.blue),
    .outline_px   (rsp.outline_px)
);

`default_nettype wire

@@ tb/monocular_object_proximity_zone_test.sv @@
`timescale 1ns / 1ps

module monocular_object_proximity_zone_test;
    import mopz_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 150;
    localparam int ONE_PX       = 1 << PIXEL_FRAC_BITS;

    // One expected result item
    typedef struct {
        logic signed [DIST_W-1:0] distance_mm;
        zone_t                    zone;
        logic [7:0]               red;
        logic [7:0]               green;
        logic [7:0]               blue;
        logic [2:0]               outline_px;
    } dist_result_t;

    // Directed stimulus row; known rows carry a result typed in by hand
    typedef struct {
        logic [7:0]               obj_class;
        logic [15:0]              box_top;
        logic [15:0]              box_height;
        bit                       known;
        logic signed [DIST_W-1:0] distance_mm;
        zone_t                    zone;
        logic [7:0]               red;
        logic [7:0]               green;
        logic [7:0]               blue;
        logic [2:0]               outline_px;
    } object_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [REG_W-1:0] cfg_wdata;

    mopz_obj_if req_ch ();
    mopz_res_if rsp_ch ();

    monocular_object_proximity_zone u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    logic [REG_W-1:0] cam_regs [NUM_REGS];
    dist_result_t     pending_dist[$];
    int               mismatches;
    int               cycle_count;
    int               tx_idle_pct;
    int               rx_idle_pct;
    bit               hold_off_req;

    object_row_t directed_rows [] = '{
        // both divisors under one pixel: sentinel average
        '{8'd0,   16'hFFFF, 16'd0,     1'b1, -25'sd1000, ZONE_CRITICAL, 8'd255, 8'd0, 8'd0,
          3'd5},
        // tallest box: small pinhole estimate averaged with the ground sentinel
        '{8'd255, 16'hFFFF, 16'hFFFF,  1'b1, -25'sd372, ZONE_CRITICAL, 8'd255, 8'd0, 8'd0,
          3'd5},
        '{8'd1,   16'd5000, 16'd15,    1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        '{8'd2,   16'd0,    16'd16,    1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        '{8'd3,   16'd0,    16'd1,     1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        '{8'd4,   16'd2000, 16'd400,   1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        // ground divisor exactly one pixel, then just under
        '{8'd0,   16'd5000, 16'd744,   1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        '{8'd0,   16'd5001, 16'd744,   1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        '{8'd0,   16'd0,    16'd0,     1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        '{8'd2,   16'd3000, 16'd1000,  1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        '{8'd1,   16'd2800, 16'd300,   1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        '{8'd3,   16'd2900, 16'd100,   1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        '{8'd0,   16'd2880, 16'd60,    1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        '{8'd128, 16'd0,    16'h8000,  1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        '{8'd200, 16'h8000, 16'd32,    1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0},
        '{8'd5,   16'd5000, 16'd700,   1'b0, '0, ZONE_CRITICAL, '0, '0, '0, '0}
    };

    // Clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Distance and zone for one object under the current register values
    function automatic dist_result_t predict_distance(logic [7:0] cls, logic [15:0] top,
                                                      logic [15:0] hgt);
        longint real_h;
        longint pin_mm;
        longint gnd_mm;
        longint ydiff;
        longint avg;
        dist_result_t r;
        real_h = (cls < 4) ? longint'(cam_regs[REG_CLASS0 + cls]) :
                             longint'(cam_regs[REG_DEFAULT]);
        ydiff  = (longint'(cam_regs[REG_IMG]) <<< PIXEL_FRAC_BITS)
                 - (longint'(top) + longint'(hgt));
        if (hgt < ONE_PX)
            pin_mm = -1000;
        else
            pin_mm = ((real_h * longint'(cam_regs[REG_FOCAL])) <<< PIXEL_FRAC_BITS)
                     / longint'(hgt);
        if (ydiff < ONE_PX)
            gnd_mm = -1000;
        else
            gnd_mm = ((longint'(cam_regs[REG_CAM]) * longint'(cam_regs[REG_FOCAL]))
                      <<< PIXEL_FRAC_BITS) / ydiff;
        avg = (pin_mm + gnd_mm) >>> 1;
        r.distance_mm = avg[DIST_W-1:0];
        r.blue = 8'd0;
        if (avg < 3000)
        begin
            r.zone = ZONE_CRITICAL; r.red = 8'd255; r.green = 8'd0; r.outline_px = 3'd5;
        end
        else if (avg < 10000)
        begin
            r.zone = ZONE_WARNING; r.red = 8'd255; r.green = ORANGE_GREEN;
            r.outline_px = 3'd4;
        end
        else if (avg < 20000)
        begin
            r.zone = ZONE_CAUTION; r.red = 8'd255; r.green = 8'd255; r.outline_px = 3'd3;
        end
        else
        begin
            r.zone = ZONE_SAFE; r.red = 8'd0; r.green = 8'd255; r.outline_px = 3'd3;
        end
        return r;
    endfunction

    // Register write; the block ignores indexes past the last register
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx < NUM_REGS)
            cam_regs[idx] = val;
    endtask

    // Offer one object item and hold it until accepted
    task automatic send_object(logic [7:0] cls, logic [15:0] top, logic [15:0] hgt,
                               bit known, dist_result_t typed);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.obj_class  = cls;
        req_ch.box_top    = top;
        req_ch.box_height = hgt;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_dist.push_back(known ? typed : predict_distance(cls, top, hgt));
    endtask

    // Random object, mostly inside the frame so both estimates are live
    task automatic send_random_object();
        logic [7:0]  cls;
        logic [15:0] top;
        logic [15:0] hgt;
        int          frame;
        dist_result_t none;
        frame = int'(cam_regs[REG_IMG]) * ONE_PX;
        if (frame > 65535)
            frame = 65535;
        cls = ($urandom_range(9) < 7) ? 8'($urandom_range(4)) : 8'($urandom_range(255));
        case ($urandom_range(9))
            0: hgt = 16'($urandom_range(ONE_PX));
            1: hgt = 16'($urandom_range(65535));
            default: hgt = 16'($urandom_range(frame, ONE_PX));
        endcase
        if ($urandom_range(9) < 8)
            top = 16'($urandom_range(frame));
        else
            top = 16'($urandom_range(65535));
        none = '{'0, ZONE_CRITICAL, '0, '0, '0, '0};
        send_object(cls, top, hgt, 1'b0, none);
    endtask

    // Idle until every expected result is back
    task automatic drain();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_dist.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Receiver: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready = 1'b0;
            end
            else
                rsp_ch.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        dist_result_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_dist.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: distance %0d zone %0d",
                             rsp_ch.distance_mm, rsp_ch.zone);
            end
            else
            begin
                e = pending_dist.pop_front();
                if (rsp_ch.distance_mm !== e.distance_mm || rsp_ch.zone !== e.zone
                    || rsp_ch.red !== e.red || rsp_ch.green !== e.green
                    || rsp_ch.blue !== e.blue || rsp_ch.outline_px !== e.outline_px)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp d=%0d z=%0d rgb=%0d,%0d,%0d w=%0d  got d=%0d z=%0d rgb=%0d,%0d,%0d w=%0d",
                                 e.distance_mm, e.zone, e.red, e.green, e.blue,
                                 e.outline_px, rsp_ch.distance_mm, rsp_ch.zone,
                                 rsp_ch.red, rsp_ch.green, rsp_ch.blue,
                                 rsp_ch.outline_px);
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        dist_result_t typed;
        mismatches   = 0;
        cycle_count  = 0;
        hold_off_req = 1'b0;
        tx_idle_pct  = 26;
        rx_idle_pct  = 47;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        req_ch.valid      = 1'b0;
        req_ch.obj_class  = '0;
        req_ch.box_top    = '0;
        req_ch.box_height = '0;
        rsp_ch.ready      = 1'b0;
        cam_regs = '{CFG_RESET.focal_px, CFG_RESET.camera_height_mm,
                     CFG_RESET.image_height_px, CFG_RESET.class0_height_mm,
                     CFG_RESET.class1_height_mm, CFG_RESET.class2_height_mm,
                     CFG_RESET.class3_height_mm, CFG_RESET.default_height_mm};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items at reset register values
        foreach (directed_rows[i])
        begin
            typed = '{directed_rows[i].distance_mm, directed_rows[i].zone,
                      directed_rows[i].red, directed_rows[i].green,
                      directed_rows[i].blue, directed_rows[i].outline_px};
            send_object(directed_rows[i].obj_class, directed_rows[i].box_top,
                        directed_rows[i].box_height, directed_rows[i].known, typed);
        end
        drain();

        // Random phases over several register settings
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 3)
            begin
                tx_idle_pct = 47;
                rx_idle_pct = 26;
            end
            else if (ph == 5)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (ph)
                1:
                    // all registers at their maximum
                    for (int r = 0; r < NUM_REGS; r++)
                        write_reg(IDX_W'(r), 12'hFFF);
                2:
                begin
                    // everything at zero: zero estimates and a negative ground divisor
                    for (int r = 0; r < NUM_REGS; r++)
                        write_reg(IDX_W'(r), 12'h000);
                    write_reg(4'd15, 12'hABC);
                end
                3:
                begin
                    write_reg(REG_FOCAL, 12'd1);
                    write_reg(REG_IMG, 12'd1);
                    write_reg(REG_CAM, 12'd4095);
                    write_reg(4'd8, 12'h555);
                end
                default:
                    if (ph != 0)
                        for (int r = 0; r < NUM_REGS; r++)
                            write_reg(IDX_W'(r), 12'($urandom_range(4095, 1)));
            endcase
            if (ph == 1)
                hold_off_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_object();
            drain();
        end

        if (mismatches == 0 && pending_dist.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
